[sv/fpblc_pkg.sv]
package fpblc_pkg;

    localparam int TIME_BITS_DEFAULT = 32;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [7:0]  DEBOUNCE_RESET   = 8'd20;
    localparam logic [15:0] LONG_PRESS_RESET = 16'd1200;

    // Half periods of the blink modes, in ticks.
    localparam int BLINK_SLOW_MS = 1000;
    localparam int BLINK_MID_MS  = 300;
    localparam int BLINK_FAST_MS = 50;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DEBOUNCE   = 2'd0,
        CFG_LONG_PRESS = 2'd1
    } t_cfg_index;

    typedef enum logic [2:0] {
        LED_OFF   = 3'd0,
        LED_ON    = 3'd1,
        LED_B1000 = 3'd2,
        LED_B300  = 3'd3,
        LED_B50   = 3'd4
    } t_led_mode;

    typedef enum logic [2:0] {
        LCMD_NONE      = 3'd0,
        LCMD_HEAT      = 3'd1,
        LCMD_HEAT_OFF  = 3'd2,
        LCMD_QUICKSTOP = 3'd3,
        LCMD_RETRACT   = 3'd4,
        LCMD_FEED      = 3'd5
    } t_load_cmd;

    typedef enum logic [2:0] {
        PCMD_NONE   = 3'd0,
        PCMD_START  = 3'd1,
        PCMD_PAUSE  = 3'd2,
        PCMD_RESUME = 3'd3,
        PCMD_PARK   = 3'd4,
        PCMD_ABORT  = 3'd5
    } t_print_cmd;

    typedef struct packed {
        logic feed_pressed;
        logic retract_pressed;
        logic print_pressed;
        logic printing_active;
        logic hot_enough;
        logic card_ready;
        logic has_files;
    } t_in_item;

    typedef struct packed {
        logic       led_lit;
        logic [2:0] load_command;
        logic [2:0] print_command;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  debounce_ms;
        logic [15:0] long_press_ms;
    } t_cfg;

endpackage

[sv/front_panel_button_led_controller_top.sv]
// Channel   Direction  Handshake                 Payload
// in        input      i_in_valid / o_in_stall   i_in_item  (t_in_item, one tick)
// out       output     o_out_valid / i_out_stall o_out_item (t_out_item)
// cfg       input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One tick per cycle sustained while the output is not stalled; a tick's result passes
// through the input register and the result register around the single step stage.
// Synchronous active-low reset clears all control state and loads the register defaults.
// A stalled output holds its result while one more tick waits in the input register;
// the input stalls only when both registers are full and the output is stalled.
// Configuration writes complete in the cycle they are presented.
module front_panel_button_led_controller_top #(
    parameter int TIME_BITS = fpblc_pkg::TIME_BITS_DEFAULT
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  fpblc_pkg::t_in_item                  i_in_item,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output fpblc_pkg::t_out_item                 o_out_item,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [fpblc_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [fpblc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import fpblc_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    t_cfg      r_cfg;
    t_out_item step_result;
    logic      advance;

    assign advance     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && r_out_valid && i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign o_cfg_ready = 1'b1;

    fpblc_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_cfg    (r_cfg),
        .i_item   (r_in_item),
        .o_result (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cfg.debounce_ms   <= DEBOUNCE_RESET;
            r_cfg.long_press_ms <= LONG_PRESS_RESET;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_DEBOUNCE:   r_cfg.debounce_ms   <= i_cfg_data[7:0];
                    CFG_LONG_PRESS: r_cfg.long_press_ms <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_item <= i_in_item;
        end
        if (advance) begin
            r_out_item <= step_result;
        end
    end

    a_pending_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_out_valid && i_out_stall |=> r_in_valid && r_out_valid)
        else $error("pending tick lost while the output was stalled");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("step result not registered");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |=> $stable(r_out_item))
        else $error("stalled result changed");

endmodule

[sv/fpblc_core.sv]
module fpblc_core #(
    parameter int TIME_BITS = fpblc_pkg::TIME_BITS_DEFAULT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  fpblc_pkg::t_cfg      i_cfg,
    input  fpblc_pkg::t_in_item  i_item,
    output fpblc_pkg::t_out_item o_result
);
    import fpblc_pkg::*;

    typedef enum logic [1:0] {
        LOAD_IDLE     = 2'd0,
        LOAD_DEBOUNCE = 2'd1,
        LOAD_HEAT     = 2'd2,
        LOAD_MACRO    = 2'd3
    } t_load_phase;

    typedef enum logic [1:0] {
        KEY_IDLE     = 2'd0,
        KEY_DEBOUNCE = 2'd1,
        KEY_HELD     = 2'd2
    } t_key_phase;

    typedef enum logic [1:0] {
        PMODE_START  = 2'd0,
        PMODE_PAUSE  = 2'd1,
        PMODE_RESUME = 2'd2
    } t_print_mode;

    logic [TIME_BITS-1:0] r_now, n_now;
    t_led_mode            r_led_mode, n_led_mode;
    t_led_mode            r_last_mode, n_last_mode;
    logic [TIME_BITS-1:0] r_blink_start, n_blink_start;
    logic                 r_led_level, n_led_level;
    t_load_phase          r_load_phase, n_load_phase;
    logic [TIME_BITS-1:0] r_load_stamp, n_load_stamp;
    logic                 r_macro_sent, n_macro_sent;
    t_key_phase           r_key_phase, n_key_phase;
    logic [TIME_BITS-1:0] r_key_stamp, n_key_stamp;
    t_print_mode          r_print_mode, n_print_mode;

    logic                 blink_on;
    logic [TIME_BITS-1:0] half_period;
    logic [TIME_BITS-1:0] full_period;
    logic [TIME_BITS-1:0] phase_start;
    logic [TIME_BITS-1:0] debounce_t;
    logic [TIME_BITS-1:0] short_limit;
    logic                 toggled;
    t_load_cmd            load_cmd;
    t_print_cmd           print_cmd;

    // True while now has not yet reached t, on wrapping time.
    function automatic logic not_reached(input logic [TIME_BITS-1:0] now,
                                         input logic [TIME_BITS-1:0] t);
        logic [TIME_BITS-1:0] diff;
        diff = now - t;
        return diff[TIME_BITS-1];
    endfunction

    assign debounce_t  = TIME_BITS'(i_cfg.debounce_ms);
    assign short_limit = r_key_stamp + TIME_BITS'(i_cfg.long_press_ms) - debounce_t;
    assign toggled     = i_item.feed_pressed | i_item.retract_pressed;
    assign full_period = {half_period[TIME_BITS-2:0], 1'b0};
    assign phase_start = (r_last_mode != r_led_mode) ? r_now : r_blink_start;

    always_comb begin
        blink_on    = 1'b1;
        half_period = '0;
        case (r_led_mode)
            LED_B1000: half_period = TIME_BITS'(BLINK_SLOW_MS);
            LED_B300:  half_period = TIME_BITS'(BLINK_MID_MS);
            LED_B50:   half_period = TIME_BITS'(BLINK_FAST_MS);
            default:   blink_on    = 1'b0;
        endcase
    end

    always_comb begin
        n_now         = r_now + TIME_BITS'(1);
        n_led_mode    = r_led_mode;
        n_last_mode   = r_last_mode;
        n_blink_start = r_blink_start;
        n_led_level   = r_led_level;
        n_load_phase  = r_load_phase;
        n_load_stamp  = r_load_stamp;
        n_macro_sent  = r_macro_sent;
        n_key_phase   = r_key_phase;
        n_key_stamp   = r_key_stamp;
        n_print_mode  = r_print_mode;
        load_cmd      = LCMD_NONE;
        print_cmd     = PCMD_NONE;

        // Status LED, driven from the mode left by the previous tick.
        if (r_led_mode == LED_OFF) begin
            n_led_level = 1'b0;
        end else if (!blink_on) begin
            n_led_level = 1'b1;
        end else begin
            if (r_last_mode != r_led_mode) begin
                n_last_mode   = r_led_mode;
                n_blink_start = r_now;
            end
            if (not_reached(r_now, phase_start + half_period)) begin
                n_led_level = 1'b1;
            end else if (not_reached(r_now, phase_start + full_period)) begin
                n_led_level = 1'b0;
            end else begin
                n_blink_start = r_now;
            end
        end

        // Filament sequencer, held while a print runs.
        if (!i_item.printing_active) begin
            unique case (r_load_phase)
                LOAD_IDLE: begin
                    if (toggled) begin
                        n_load_phase = LOAD_DEBOUNCE;
                        n_load_stamp = r_now;
                    end
                end
                LOAD_DEBOUNCE: begin
                    if (!not_reached(r_now, r_load_stamp + debounce_t)) begin
                        if (toggled) begin
                            load_cmd     = LCMD_HEAT;
                            n_led_mode   = LED_B50;
                            n_load_phase = LOAD_HEAT;
                        end else begin
                            n_load_phase = LOAD_IDLE;
                        end
                    end
                end
                LOAD_HEAT: begin
                    if (!toggled) begin
                        n_led_mode   = LED_ON;
                        n_load_phase = LOAD_IDLE;
                        load_cmd     = LCMD_HEAT_OFF;
                    end else if (i_item.hot_enough) begin
                        n_load_phase = LOAD_MACRO;
                        n_led_mode   = LED_B300;
                    end
                end
                LOAD_MACRO: begin
                    if (!toggled) begin
                        n_macro_sent = 1'b0;
                        n_load_phase = LOAD_IDLE;
                        load_cmd     = LCMD_QUICKSTOP;
                        n_led_mode   = LED_ON;
                    end else if (!r_macro_sent) begin
                        n_macro_sent = 1'b1;
                        load_cmd     = i_item.retract_pressed ? LCMD_RETRACT : LCMD_FEED;
                    end
                end
            endcase
        end

        // Print button; its LED mode overrides the sequencer's.
        unique case (r_key_phase)
            KEY_IDLE: begin
                if (i_item.print_pressed) begin
                    n_key_stamp = r_now;
                    n_key_phase = KEY_DEBOUNCE;
                end
            end
            KEY_DEBOUNCE: begin
                if (!not_reached(r_now, r_key_stamp + debounce_t)) begin
                    n_key_phase = i_item.print_pressed ? KEY_HELD : KEY_IDLE;
                end
            end
            KEY_HELD: begin
                if (!i_item.print_pressed) begin
                    n_key_phase = KEY_IDLE;
                    if (not_reached(r_now, short_limit)) begin
                        case (r_print_mode)
                            PMODE_START: begin
                                if (!i_item.printing_active) begin
                                    if (!i_item.card_ready) begin
                                        n_led_mode = LED_OFF;
                                    end else begin
                                        n_led_mode   = LED_B1000;
                                        n_print_mode = PMODE_PAUSE;
                                        if (i_item.has_files) begin
                                            print_cmd = PCMD_START;
                                        end
                                    end
                                end
                            end
                            PMODE_PAUSE: begin
                                if (i_item.printing_active) begin
                                    n_led_mode   = LED_ON;
                                    print_cmd    = PCMD_PAUSE;
                                    n_print_mode = PMODE_RESUME;
                                end
                            end
                            PMODE_RESUME: begin
                                if (!i_item.printing_active) begin
                                    n_led_mode   = LED_B1000;
                                    print_cmd    = PCMD_RESUME;
                                    n_print_mode = PMODE_PAUSE;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end else begin
                        if (r_print_mode == PMODE_START && !i_item.printing_active) begin
                            n_led_mode = LED_ON;
                            print_cmd  = PCMD_PARK;
                        end else begin
                            n_led_mode = LED_OFF;
                            print_cmd  = PCMD_ABORT;
                        end
                        n_print_mode = PMODE_START;
                    end
                end
            end
            default: begin
                n_key_phase = KEY_IDLE;
            end
        endcase
    end

    assign o_result.led_lit       = n_led_level;
    assign o_result.load_command  = load_cmd;
    assign o_result.print_command = print_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now         <= '0;
            r_led_mode    <= LED_ON;
            r_last_mode   <= LED_OFF;
            r_blink_start <= '0;
            r_led_level   <= 1'b0;
            r_load_phase  <= LOAD_IDLE;
            r_load_stamp  <= '0;
            r_macro_sent  <= 1'b0;
            r_key_phase   <= KEY_IDLE;
            r_key_stamp   <= '0;
            r_print_mode  <= PMODE_START;
        end else if (i_en) begin
            r_now         <= n_now;
            r_led_mode    <= n_led_mode;
            r_last_mode   <= n_last_mode;
            r_blink_start <= n_blink_start;
            r_led_level   <= n_led_level;
            r_load_phase  <= n_load_phase;
            r_load_stamp  <= n_load_stamp;
            r_macro_sent  <= n_macro_sent;
            r_key_phase   <= n_key_phase;
            r_key_stamp   <= n_key_stamp;
            r_print_mode  <= n_print_mode;
        end
    end

    a_tick_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en |=> r_now == $past(r_now) + TIME_BITS'(1))
        else $error("tick counter did not advance with a transfer");

    a_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> $stable(r_now) && $stable(r_load_phase) && $stable(r_key_phase))
        else $error("state changed without a transfer");

    a_macro_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_macro_sent |-> r_load_phase == LOAD_MACRO)
        else $error("macro flag set outside the macro phase");

endmodule

[tb/sv/tb.sv]
module tb;
    import fpblc_pkg::*;

    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int HOLDOFF_CYCLES = 120;

    // Register indexes past the end of the map; writes to them must be dropped.
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = 2'd3;

    localparam t_in_item RELEASED = '0;

    typedef enum logic [1:0] {FIL_IDLE, FIL_DEBOUNCE, FIL_HEATING, FIL_MOVING} t_fil_phase;
    typedef enum logic [1:0] {BTN_IDLE, BTN_DEBOUNCE, BTN_HELD} t_btn_phase;
    typedef enum logic [1:0] {RUN_START, RUN_ACTIVE, RUN_PAUSED} t_run_mode;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_in_valid  = 1'b0;
    t_in_item               i_in_item   = '0;
    logic                   i_out_stall = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;
    logic                   o_in_stall;
    logic                   o_out_valid;
    t_out_item              o_out_item;
    logic                   o_cfg_ready;

    // Predicted panel state and its copy of the registers.
    logic [7:0]  cfg_debounce = DEBOUNCE_RESET;
    logic [15:0] cfg_long     = LONG_PRESS_RESET;
    logic [31:0] tick_ms      = '0;
    t_led_mode   led_sel      = LED_ON;
    t_led_mode   led_sel_seen = LED_OFF;
    logic [31:0] blink_origin = '0;
    logic        lamp_level   = 1'b0;
    t_fil_phase  fil_phase    = FIL_IDLE;
    logic [31:0] fil_since    = '0;
    logic        macro_done   = 1'b0;
    t_btn_phase  btn_phase    = BTN_IDLE;
    logic [31:0] btn_since    = '0;
    t_run_mode   run_mode     = RUN_START;

    t_out_item pending_results[$];
    t_out_item want;
    int        ticks_sent    = 0;
    int        results_seen  = 0;
    int        errors        = 0;
    int        cycle_count   = 0;
    int        send_idle_pct = 0;
    int        stall_pct     = 0;
    int        stall_run     = 0;
    logic      holding_off   = 1'b0;
    event      holdoff_go;

    front_panel_button_led_controller_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // True while time t has not been reached yet, with wraparound.
    function automatic logic not_yet(input logic [31:0] now_t, input logic [31:0] t);
        logic [31:0] diff;
        diff = now_t - t;
        return diff[31];
    endfunction

    function automatic t_out_item advance_panel(input t_in_item it);
        logic [31:0] half;
        logic [31:0] limit;
        logic        toggled;
        t_load_cmd   lc;
        t_print_cmd  pc;
        t_out_item   r;
        lc = LCMD_NONE;
        pc = PCMD_NONE;
        toggled = it.feed_pressed | it.retract_pressed;

        case (led_sel)
            LED_OFF: lamp_level = 1'b0;
            LED_B1000, LED_B300, LED_B50: begin
                half = (led_sel == LED_B1000) ? 32'(BLINK_SLOW_MS) :
                       (led_sel == LED_B300)  ? 32'(BLINK_MID_MS)  : 32'(BLINK_FAST_MS);
                if (led_sel_seen != led_sel) begin
                    led_sel_seen = led_sel;
                    blink_origin = tick_ms;
                end
                if (not_yet(tick_ms, blink_origin + half)) lamp_level = 1'b1;
                else if (not_yet(tick_ms, blink_origin + 2 * half)) lamp_level = 1'b0;
                else blink_origin = tick_ms;
            end
            default: lamp_level = 1'b1;
        endcase

        if (!it.printing_active) begin
            case (fil_phase)
                FIL_IDLE: begin
                    if (toggled) begin
                        fil_phase = FIL_DEBOUNCE;
                        fil_since = tick_ms;
                    end
                end
                FIL_DEBOUNCE: begin
                    if (!not_yet(tick_ms, fil_since + cfg_debounce)) begin
                        if (toggled) begin
                            lc = LCMD_HEAT;
                            led_sel = LED_B50;
                            fil_phase = FIL_HEATING;
                        end else begin
                            fil_phase = FIL_IDLE;
                        end
                    end
                end
                FIL_HEATING: begin
                    if (!toggled) begin
                        led_sel = LED_ON;
                        fil_phase = FIL_IDLE;
                        lc = LCMD_HEAT_OFF;
                    end else if (it.hot_enough) begin
                        fil_phase = FIL_MOVING;
                        led_sel = LED_B300;
                    end
                end
                default: begin
                    if (!toggled) begin
                        macro_done = 1'b0;
                        fil_phase = FIL_IDLE;
                        lc = LCMD_QUICKSTOP;
                        led_sel = LED_ON;
                    end else if (!macro_done) begin
                        macro_done = 1'b1;
                        lc = it.retract_pressed ? LCMD_RETRACT : LCMD_FEED;
                    end
                end
            endcase
        end

        case (btn_phase)
            BTN_IDLE: begin
                if (it.print_pressed) begin
                    btn_since = tick_ms;
                    btn_phase = BTN_DEBOUNCE;
                end
            end
            BTN_DEBOUNCE: begin
                if (!not_yet(tick_ms, btn_since + cfg_debounce))
                    btn_phase = it.print_pressed ? BTN_HELD : BTN_IDLE;
            end
            BTN_HELD: begin
                if (!it.print_pressed) begin
                    btn_phase = BTN_IDLE;
                    limit = btn_since + cfg_long - cfg_debounce;
                    if (not_yet(tick_ms, limit)) begin
                        case (run_mode)
                            RUN_START: begin
                                if (!it.printing_active) begin
                                    if (!it.card_ready) begin
                                        led_sel = LED_OFF;
                                    end else begin
                                        led_sel = LED_B1000;
                                        run_mode = RUN_ACTIVE;
                                        if (it.has_files) pc = PCMD_START;
                                    end
                                end
                            end
                            RUN_ACTIVE: begin
                                if (it.printing_active) begin
                                    led_sel = LED_ON;
                                    pc = PCMD_PAUSE;
                                    run_mode = RUN_PAUSED;
                                end
                            end
                            RUN_PAUSED: begin
                                if (!it.printing_active) begin
                                    led_sel = LED_B1000;
                                    pc = PCMD_RESUME;
                                    run_mode = RUN_ACTIVE;
                                end
                            end
                            default: ;
                        endcase
                    end else begin
                        if (run_mode == RUN_START && !it.printing_active) begin
                            led_sel = LED_ON;
                            pc = PCMD_PARK;
                        end else begin
                            led_sel = LED_OFF;
                            pc = PCMD_ABORT;
                        end
                        run_mode = RUN_START;
                    end
                end
            end
            default: btn_phase = BTN_IDLE;
        endcase

        r.led_lit       = lamp_level;
        r.load_command  = lc;
        r.print_command = pc;
        tick_ms = tick_ms + 1;
        return r;
    endfunction

    // Mostly no gap; when there is one it is usually short, now and then long.
    function automatic int pick_gap(input int pct);
        if ($urandom % 100 >= pct) return 0;
        if ($urandom % 10 < 8) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // Hold length for a switch or the button, clustered around the debounce
    // time and around the short/long boundary.
    function automatic int pick_hold();
        int boundary;
        int lim;
        boundary = int'(cfg_long) - int'(cfg_debounce);
        case ($urandom % 3)
            0: return $urandom_range(int'(cfg_debounce) + 3, 0);
            1: begin
                if (boundary >= 0 && boundary < 400)
                    return $urandom_range(boundary + 3, (boundary > 3) ? boundary - 3 : 0);
            end
            default: ;
        endcase
        lim = int'(cfg_long) + int'(cfg_debounce) + 10;
        return $urandom_range((lim > 300) ? 300 : lim, 0);
    endfunction

    task automatic log_mismatch(input string what);
        errors++;
        if (errors <= 100) $display("MISMATCH at result %0d: %s", results_seen, what);
    endtask

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_tick(input t_in_item it);
        int gap;
        gap = pick_gap(send_idle_pct);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_results.push_back(advance_panel(it));
        ticks_sent++;
        @(negedge i_clk);
    endtask

    task automatic hold(input t_in_item it, input int n);
        repeat (n) send_tick(it);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    // Leaves valid high; the caller lowers it after its last write.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_DEBOUNCE:   cfg_debounce = data[7:0];
            CFG_LONG_PRESS: cfg_long     = data;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic configure(input logic [7:0] deb, input logic [15:0] long_ms);
        drain();
        if ($urandom % 2)
            write_reg(($urandom % 2) ? CFG_SPARE_A : CFG_SPARE_B, 16'($urandom));
        write_reg(CFG_DEBOUNCE, {8'($urandom), deb});
        write_reg(CFG_LONG_PRESS, long_ms);
        if ($urandom % 2)
            write_reg(($urandom % 2) ? CFG_SPARE_A : CFG_SPARE_B, 16'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_in_item panel_in(input bit f, r, p, pa, h, c, fi);
        return t_in_item'({f, r, p, pa, h, c, fi});
    endfunction

    task automatic run_random(input int n);
        int       stop_at;
        int       kind;
        int       len;
        int       hot_at;
        int       sel;
        t_in_item it;
        stop_at = ticks_sent + n;
        while (ticks_sent < stop_at) begin
            kind = $urandom % 100;
            it = '0;
            it.printing_active = ($urandom % 10) < 3;
            it.card_ready      = ($urandom % 10) < 8;
            it.has_files       = ($urandom % 10) < 7;
            it.hot_enough      = ($urandom % 2) == 1;
            if (kind < 35) begin
                it.print_pressed = 1'b1;
                hold(it, pick_hold());
                it.print_pressed = 1'b0;
                if ($urandom % 4 == 0) it.printing_active = ~it.printing_active;
                send_tick(it);
            end else if (kind < 70) begin
                sel = $urandom % 3;
                it.feed_pressed    = (sel != 1);
                it.retract_pressed = (sel != 0);
                it.printing_active = ($urandom % 10) == 0;
                len = pick_hold();
                hot_at = $urandom_range(len + 2, 0);
                for (int i = 0; i < len; i++) begin
                    it.hot_enough = (i >= hot_at);
                    send_tick(it);
                end
                it.feed_pressed    = 1'b0;
                it.retract_pressed = 1'b0;
                send_tick(it);
            end else if (kind < 85) begin
                repeat ($urandom_range(6, 1)) send_tick(t_in_item'(7'($urandom)));
            end else begin
                hold(it, $urandom_range(15, 1));
            end
        end
    endtask

    // Register reset values: a switch released inside the debounce window, then
    // a short press that starts a print and a retract cycle.
    task automatic test_reset_defaults();
        send_idle_pct = 20;
        stall_pct = 20;
        hold(panel_in(1, 0, 0, 0, 0, 0, 0), 5);
        hold(RELEASED, 20);
        hold(panel_in(0, 0, 1, 0, 0, 1, 1), 22);
        hold(panel_in(0, 0, 0, 0, 0, 1, 1), 1);
        hold(panel_in(0, 1, 0, 0, 1, 0, 0), 24);
        hold(RELEASED, 2);
    endtask

    // Zero debounce makes every command reachable in a few ticks.
    task automatic test_directed();
        configure(8'd0, 16'd3);
        send_idle_pct = 0;
        stall_pct = 0;
        // Pause while printing; the switch is ignored during a print.
        hold(panel_in(1, 0, 1, 1, 0, 0, 0), 2);
        hold(panel_in(0, 0, 0, 1, 0, 0, 0), 1);
        // Resume.
        hold(panel_in(0, 0, 1, 0, 0, 0, 0), 2);
        hold(RELEASED, 1);
        // Both switch sides pick retract; the short press does not fit and is dropped.
        hold(panel_in(1, 1, 1, 0, 1, 0, 0), 2);
        hold(panel_in(1, 1, 0, 0, 1, 0, 0), 2);
        hold(RELEASED, 1);
        // Long press while running aborts.
        hold(panel_in(0, 0, 1, 1, 0, 0, 0), 3);
        hold(panel_in(0, 0, 0, 1, 0, 0, 0), 1);
        // Card fails to mount; the button's LED choice beats the switch's.
        hold(panel_in(1, 0, 1, 0, 0, 0, 0), 2);
        hold(RELEASED, 1);
        // Long press when idle parks, alongside a full feed cycle.
        hold(panel_in(1, 0, 1, 0, 1, 0, 0), 3);
        hold(panel_in(1, 0, 0, 0, 1, 0, 0), 1);
        hold(RELEASED, 1);
        // Card mounts but holds no files.
        hold(panel_in(0, 1, 1, 0, 1, 1, 0), 2);
        hold(panel_in(0, 0, 0, 0, 1, 1, 0), 1);
    endtask

    // Long holds so that the two faster blink rates change level and restart,
    // then a pause and a resume with the card mounted leave the slow blink running.
    task automatic test_blink_soak();
        configure(8'd1, 16'd10);
        send_idle_pct = 5;
        stall_pct = 5;
        hold(panel_in(1, 0, 0, 0, 0, 0, 0), 130);
        hold(panel_in(1, 0, 0, 0, 1, 0, 0), 650);
        hold(RELEASED, 1);
        hold(panel_in(0, 0, 1, 1, 0, 0, 0), 3);
        hold(panel_in(0, 0, 0, 1, 0, 0, 0), 1);
        hold(panel_in(0, 0, 1, 0, 0, 1, 0), 3);
        hold(RELEASED, 30);
    endtask

    task automatic test_backpressure();
        configure(8'd2, 16'd8);
        send_idle_pct = 0;
        stall_pct = 0;
        -> holdoff_go;
        run_random(80);
    endtask

    task automatic test_random();
        logic [7:0]  deb_set[6]  = '{8'd2, 8'd0, 8'd6, 8'd255, 8'd1, 8'd3};
        logic [15:0] long_set[6] = '{16'd8, 16'd0, 16'd2, 16'd65535, 16'd30, 16'd1200};
        int          idle_set[6] = '{30, 0, 20, 10, 40, 15};
        int          stall_set[6] = '{30, 20, 0, 10, 40, 15};
        for (int i = 0; i < 6; i++) begin
            configure(deb_set[i], long_set[i]);
            send_idle_pct = idle_set[i];
            stall_pct = stall_set[i];
            run_random(80);
        end
    endtask

    always begin
        @(holdoff_go);
        @(posedge i_clk);
        holding_off = 1'b1;
        repeat (HOLDOFF_CYCLES) @(posedge i_clk);
        holding_off = 1'b0;
    end

    always @(negedge i_clk) begin
        if (holding_off) begin
            i_out_stall <= 1'b1;
        end else if (stall_run > 0) begin
            stall_run = stall_run - 1;
            i_out_stall <= 1'b1;
        end else begin
            stall_run = pick_gap(stall_pct);
            if (stall_run > 0) begin
                stall_run = stall_run - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                log_mismatch("result with no tick outstanding");
            end else begin
                want = pending_results.pop_front();
                if (o_out_item.led_lit !== want.led_lit)
                    log_mismatch($sformatf("led_lit got %0b, expected %0b",
                                           o_out_item.led_lit, want.led_lit));
                if (o_out_item.load_command !== want.load_command)
                    log_mismatch($sformatf("load_command got %0d, expected %0d",
                                           o_out_item.load_command, want.load_command));
                if (o_out_item.print_command !== want.print_command)
                    log_mismatch($sformatf("print_command got %0d, expected %0d",
                                           o_out_item.print_command, want.print_command));
            end
            results_seen++;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_reset_defaults();
        test_directed();
        test_blink_soak();
        test_backpressure();
        test_random();
        drain();
        repeat (8) @(negedge i_clk);
        if (errors == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

endmodule

[files.f]
sv/fpblc_pkg.sv
sv/fpblc_core.sv
sv/front_panel_button_led_controller_top.sv
tb/sv/tb.sv
